[rtl/core/esd_pkg.sv]
package esd_pkg;

  localparam int BYTE_W   = 8;
  localparam int GRP_MAX  = 4;
  localparam int CNT_W    = $clog2(GRP_MAX + 1);
  localparam int IDX_W    = $clog2(GRP_MAX);
  localparam int Q_DEPTH  = 2;
  localparam int Q_AW     = $clog2(Q_DEPTH);

  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PH_W-1:0] PH_ESC  = 3'd1;
  localparam logic [PH_W-1:0] PH_HEX1 = 3'd2;
  localparam logic [PH_W-1:0] PH_HEX2 = 3'd3;
  localparam logic [PH_W-1:0] PH_OCT1 = 3'd4;
  localparam logic [PH_W-1:0] PH_OCT2 = 3'd5;

  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_X      = 8'h78;

  // bytes produced by one request, oldest in slot 0
  typedef struct packed {
    logic [GRP_MAX-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]               cnt;
    logic                           last;
  } esd_grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } esd_q_stat_t;

  // {hit, decoded byte}
  function automatic logic [BYTE_W:0] simple_escape(input logic [BYTE_W-1:0] c);
    logic [BYTE_W:0] r;
    unique case (c)
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      8'h76:   r = {1'b1, 8'h0B};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h27:   r = {1'b1, 8'h27};
      8'h22:   r = {1'b1, 8'h22};
      default: r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

  function automatic logic is_hex(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] c);
    logic [3:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = c[3:0] + 4'd9;
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

  function automatic logic is_oct(input logic [BYTE_W-1:0] c);
    return c >= 8'h30 && c <= 8'h37;
  endfunction

endpackage

[rtl/core/esd_if.sv]
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_last;

  modport source (output valid, output in_byte, output string_last, input ready);
  modport sink   (input valid, input in_byte, input string_last, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_end,
                  output ready);
endinterface

[rtl/core/esd_front.sv]
module esd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  esd_pkg::esd_q_stat_t q_stat,
  output logic                push,
  output esd_pkg::esd_grp_t   push_grp
);
  import esd_pkg::*;

  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [BYTE_W-1:0] held0_r, held0_nxt;
  logic [BYTE_W-1:0] held1_r, held1_nxt;
  logic [GRP_MAX-1:0][BYTE_W-1:0] bytes;
  logic [CNT_W-1:0]  cnt;
  logic [BYTE_W:0]   esc;
  logic              accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_nxt = PH_IDLE;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    bytes     = '0;
    cnt       = '0;
    esc       = simple_escape(in_byte);
    unique case (phase_r)
      PH_ESC: begin
        if (esc[BYTE_W]) begin
          bytes[0] = esc[BYTE_W-1:0];
          cnt = 3'd1;
        end else if (in_byte == CH_X && !in_last) begin
          phase_nxt = PH_HEX1;
        end else if (is_oct(in_byte) && !in_last) begin
          held0_nxt = in_byte;
          phase_nxt = PH_OCT1;
        end else begin
          bytes[0] = CH_BSLASH;
          bytes[1] = in_byte;
          cnt = 3'd2;
        end
      end
      PH_HEX1: begin
        if (is_hex(in_byte) && !in_last) begin
          held0_nxt = in_byte;
          phase_nxt = PH_HEX2;
        end else begin
          bytes[0] = CH_BSLASH;
          bytes[1] = CH_X;
          cnt = 3'd2;
          if (in_byte == CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            bytes[2] = in_byte;
            cnt = 3'd3;
          end
        end
      end
      PH_HEX2: begin
        if (is_hex(in_byte)) begin
          bytes[0] = {hex_val(held0_r), hex_val(in_byte)};
          cnt = 3'd1;
        end else begin
          // held digit is never a backslash
          bytes[0] = CH_BSLASH;
          bytes[1] = CH_X;
          bytes[2] = held0_r;
          cnt = 3'd3;
          if (in_byte == CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            bytes[3] = in_byte;
            cnt = 3'd4;
          end
        end
      end
      PH_OCT1: begin
        if (is_oct(in_byte) && !in_last) begin
          held1_nxt = in_byte;
          phase_nxt = PH_OCT2;
        end else begin
          bytes[0] = CH_BSLASH;
          bytes[1] = held0_r;
          cnt = 3'd2;
          if (in_byte == CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            bytes[2] = in_byte;
            cnt = 3'd3;
          end
        end
      end
      PH_OCT2: begin
        if (is_oct(in_byte)) begin
          // value mod 256 drops the top bit of the first digit
          bytes[0] = {held0_r[1:0], held1_r[2:0], in_byte[2:0]};
          cnt = 3'd1;
        end else begin
          bytes[0] = CH_BSLASH;
          bytes[1] = held0_r;
          bytes[2] = held1_r;
          cnt = 3'd3;
          if (in_byte == CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            bytes[3] = in_byte;
            cnt = 3'd4;
          end
        end
      end
      default: begin
        if (in_byte == CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end else begin
          bytes[0] = in_byte;
          cnt = 3'd1;
        end
      end
    endcase
    if (in_last) begin
      // trailing backslash is kept; cnt is at most 3 here
      if (phase_nxt == PH_ESC) begin
        bytes[cnt[IDX_W-1:0]] = CH_BSLASH;
        cnt = cnt + 3'd1;
      end
      phase_nxt = PH_IDLE;
    end
  end

  assign push           = accept && (cnt != '0);
  assign push_grp.bytes = bytes;
  assign push_grp.cnt   = cnt;
  assign push_grp.last  = in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held0_r <= '0;
      held1_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

endmodule

[rtl/core/esd_queue.sv]
module esd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  esd_pkg::esd_grp_t    push_grp,
  input  logic                 pop,
  output esd_pkg::esd_grp_t    head_grp,
  output esd_pkg::esd_q_stat_t q_stat
);
  import esd_pkg::*;

  esd_grp_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     count_r, count_nxt;

  assign q_stat.full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_grp     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/core/esd_back.sv]
module esd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  esd_pkg::esd_grp_t    head_grp,
  input  esd_pkg::esd_q_stat_t q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_run_last,
  output logic                 out_string_end
);
  import esd_pkg::*;

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              run_last_r;
  logic              string_end_r;
  logic              load;
  logic              fin;

  assign load = !q_stat.empty && (!valid_r || out_ready);
  assign fin  = ({1'b0, idx_r} == head_grp.cnt - 1'b1);
  assign pop  = load && fin;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = fin ? '0 : idx_r + 1'b1;
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r       <= head_grp.bytes[idx_r];
      run_last_r   <= fin;
      string_end_r <= fin && head_grp.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_run_last   = run_last_r;
  assign out_string_end = string_end_r;

endmodule

[rtl/core/escape_sequence_decoder_unit.sv]
// C string unescaper. One escaped string byte is taken per cycle on in_ch
// (string_last flags the final byte) and the decoded bytes leave on out_ch,
// one per cycle while out_ch is ready; run_last marks the last byte a request
// produced and string_end the final byte of the string. A request is classified
// in the cycle it is accepted; if it yields 1 to 4 bytes they are parked as one
// group in a two-entry queue, and a request that yields none parks nothing. A
// group's first byte passes the queue and the output register before it is
// valid on out_ch, which drains a group at one byte per cycle while ready. Input
// stalls only while both queue entries hold groups that are still draining, so
// it keeps flowing at one per cycle while each request yields at most one byte
// and out_ch is ready.
module escape_sequence_decoder_unit (
  input logic clk,
  input logic rst_n,
  esd_in_if.sink    in_ch,
  esd_out_if.source out_ch
);
  import esd_pkg::*;

  esd_grp_t    push_grp;
  esd_grp_t    head_grp;
  esd_q_stat_t q_stat;
  logic        push;
  logic        pop;

  esd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.in_byte),
    .in_last  (in_ch.string_last),
    .q_stat   (q_stat),
    .push     (push),
    .push_grp (push_grp)
  );

  esd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head_grp (head_grp),
    .q_stat   (q_stat)
  );

  esd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_grp       (head_grp),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_byte       (out_ch.out_byte),
    .out_run_last   (out_ch.run_last),
    .out_string_end (out_ch.string_end)
  );

endmodule
